// ===== hdl/ehtk_pkg.sv =====
`default_nettype none

package ehtk_pkg;

    // Table geometry
    localparam int KINDS  = 10;
    localparam int IDX_W  = (KINDS > 1) ? $clog2(KINDS) : 1;
    localparam int ID_W   = 4;
    localparam int NAV_W  = 32;
    localparam int CNT_W  = 32;
    localparam int TOT_W  = 36;
    localparam int DIST_W = 5;
    localparam int LIM_W  = 5;

    localparam logic [LIM_W-1:0] TOP_LIMIT_RST = LIM_W'(6);

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input action codes
    localparam logic [1:0] ACT_HIT    = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Result record kinds
    localparam logic [1:0] REC_SUMMARY = 2'd0;
    localparam logic [1:0] REC_RANKED  = 2'd1;
    localparam logic [1:0] REC_QUERY   = 2'd2;

    typedef enum logic [1:0] {
        CMD_HIT,
        CMD_FINISH,
        CMD_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [ID_W-1:0]  id;
        logic [NAV_W-1:0] nav;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        record_kind;
        logic [NAV_W-1:0]  out_nav;
        logic [DIST_W-1:0] distinct_kinds;
        logic [TOT_W-1:0]  total_hits;
        logic [ID_W-1:0]   kind_out;
        logic [CNT_W-1:0]  kind_count;
        logic              last;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUMMARY,
        ST_SCAN,
        ST_EMIT
    } back_st_t;

endpackage

`default_nettype wire

// ===== hdl/ehtk_front.sv =====
`default_nettype none

module ehtk_front (
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_action,
    input  wire logic [ehtk_pkg::ID_W-1:0]  s_event_id,
    input  wire logic [ehtk_pkg::NAV_W-1:0] s_nav_id,
    input  wire logic                    q_full,
    output logic                         q_push,
    output ehtk_pkg::cmd_t               q_cmd
);
    import ehtk_pkg::*;

    logic id_in_range;
    logic useful;

    assign id_in_range = ({1'b0, s_event_id} < (ID_W + 1)'(KINDS));

    // Classify the request; drop unused actions and out-of-table hits here
    always_comb begin
        useful    = 1'b0;
        q_cmd.op  = CMD_HIT;
        q_cmd.id  = s_event_id;
        q_cmd.nav = s_nav_id;
        unique case (s_action)
            ACT_HIT: begin
                q_cmd.op = CMD_HIT;
                useful   = id_in_range;
            end
            ACT_FINISH: begin
                q_cmd.op = CMD_FINISH;
                useful   = 1'b1;
            end
            ACT_QUERY: begin
                q_cmd.op = CMD_QUERY;
                useful   = 1'b1;
            end
            default: begin
                useful = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && useful;

endmodule

`default_nettype wire

// ===== hdl/ehtk_queue.sv =====
`default_nettype none

module ehtk_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ehtk_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output ehtk_pkg::cmd_t      head_cmd
);
    import ehtk_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Fill count always matches pointer distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != QCNT_W'(QDEPTH)) && (count_reg != '0)
        |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// ===== hdl/ehtk_back.sv =====
`default_nettype none

module ehtk_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ehtk_pkg::LIM_W-1:0]  cfg_wr_data,
    input  wire logic                        cmd_valid,
    input  wire ehtk_pkg::cmd_t              cmd,
    output logic                             cmd_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output ehtk_pkg::rec_t                   m_rec
);
    import ehtk_pkg::*;

    back_st_t          state_reg, state_next;
    logic [CNT_W-1:0]  live_reg [KINDS];
    logic [CNT_W-1:0]  live_next [KINDS];
    logic [CNT_W-1:0]  snap_reg [KINDS];
    logic [CNT_W-1:0]  snap_next [KINDS];
    logic [NAV_W-1:0]  nav_reg, nav_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [DIST_W-1:0] distinct_reg, distinct_next;
    logic [LIM_W-1:0]  top_limit_reg;
    logic [LIM_W-1:0]  limit_reg, limit_next;
    logic [LIM_W-1:0]  rank_reg, rank_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [KINDS-1:0]  taken_reg, taken_next;
    logic              best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]  best_id_reg, best_id_next;
    logic [CNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic              out_valid_reg, out_valid_next;
    rec_t              out_reg, out_next;

    logic             out_free;
    logic             idx_last;
    logic [IDX_W-1:0] cmd_idx;
    logic             cmd_in_range;
    logic [CNT_W-1:0] scan_cnt;
    logic             cand;
    logic             rank_last;
    logic [LIM_W-1:0] lim_min;

    assign out_free     = !out_valid_reg || m_ready;
    assign idx_last     = (idx_reg == IDX_W'(KINDS - 1));
    assign cmd_idx      = cmd.id[IDX_W-1:0];
    assign cmd_in_range = ({1'b0, cmd.id} < (ID_W + 1)'(KINDS));
    assign scan_cnt     = snap_reg[idx_reg];
    assign cand         = !taken_reg[idx_reg] && (scan_cnt != '0)
                          && (!best_valid_reg || (scan_cnt > best_cnt_reg));
    assign rank_last    = (LIM_W'(rank_reg + 1'b1) == limit_reg);
    assign lim_min      = (LIM_W'(distinct_reg) < top_limit_reg)
                          ? LIM_W'(distinct_reg) : top_limit_reg;

    // Sequencer: hits, queries, and the finish sum/rank walk
    always_comb begin
        state_next      = state_reg;
        live_next       = live_reg;
        snap_next       = snap_reg;
        nav_next        = nav_reg;
        total_next      = total_reg;
        distinct_next   = distinct_reg;
        limit_next      = limit_reg;
        rank_next       = rank_reg;
        idx_next        = idx_reg;
        taken_next      = taken_reg;
        best_valid_next = best_valid_reg;
        best_id_next    = best_id_reg;
        best_cnt_next   = best_cnt_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        CMD_HIT: begin
                            cmd_pop = 1'b1;
                            if (live_reg[cmd_idx] != '1) begin
                                live_next[cmd_idx] = live_reg[cmd_idx] + 1'b1;
                            end
                        end
                        CMD_FINISH: begin
                            cmd_pop       = 1'b1;
                            snap_next     = live_reg;
                            for (int i = 0; i < KINDS; i++) begin
                                live_next[i] = '0;
                            end
                            nav_next      = cmd.nav;
                            total_next    = '0;
                            distinct_next = '0;
                            idx_next      = '0;
                            state_next    = ST_SUM;
                        end
                        CMD_QUERY: begin
                            if (out_free) begin
                                cmd_pop                 = 1'b1;
                                out_valid_next          = 1'b1;
                                out_next                = '0;
                                out_next.record_kind    = REC_QUERY;
                                out_next.kind_out       = cmd.id;
                                out_next.kind_count     = cmd_in_range
                                                          ? snap_reg[cmd_idx] : '0;
                                out_next.last           = 1'b1;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end

            // One snapshot entry per cycle into total and distinct
            ST_SUM: begin
                total_next = total_reg + TOT_W'(scan_cnt);
                if (scan_cnt != '0) begin
                    distinct_next = distinct_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_SUMMARY;
                end
            end

            ST_SUMMARY: begin
                if (total_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_next                = '0;
                    out_next.record_kind    = REC_SUMMARY;
                    out_next.out_nav        = nav_reg;
                    out_next.distinct_kinds = distinct_reg;
                    out_next.total_hits     = total_reg;
                    out_next.last           = (lim_min == '0);
                    limit_next              = lim_min;
                    rank_next               = '0;
                    taken_next              = '0;
                    idx_next                = '0;
                    best_valid_next         = 1'b0;
                    state_next              = (lim_min == '0) ? ST_IDLE : ST_SCAN;
                end
            end

            // Linear search for the largest untaken count, lower id wins ties
            ST_SCAN: begin
                if (cand) begin
                    best_valid_next = 1'b1;
                    best_id_next    = idx_reg;
                    best_cnt_next   = scan_cnt;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_next                  = '0;
                    out_next.record_kind      = REC_RANKED;
                    out_next.kind_out         = ID_W'(best_id_reg);
                    out_next.kind_count       = best_cnt_reg;
                    out_next.last             = rank_last;
                    taken_next[best_id_reg]   = 1'b1;
                    rank_next                 = LIM_W'(rank_reg + 1'b1);
                    best_valid_next           = 1'b0;
                    idx_next                  = '0;
                    state_next                = rank_last ? ST_IDLE : ST_SCAN;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < KINDS; i++) begin
                live_reg[i] <= '0;
                snap_reg[i] <= '0;
            end
            nav_reg        <= '0;
            total_reg      <= '0;
            distinct_reg   <= '0;
            top_limit_reg  <= TOP_LIMIT_RST;
            limit_reg      <= '0;
            rank_reg       <= '0;
            idx_reg        <= '0;
            taken_reg      <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            snap_reg       <= snap_next;
            nav_reg        <= nav_next;
            total_reg      <= total_next;
            distinct_reg   <= distinct_next;
            limit_reg      <= limit_next;
            rank_reg       <= rank_next;
            idx_reg        <= idx_next;
            taken_reg      <= taken_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                top_limit_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_id_reg  <= best_id_next;
        best_cnt_reg <= best_cnt_next;
        out_reg      <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_rec   = out_reg;

    // A ranking pass always finds a candidate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> best_valid_reg)
        else $error("emit without a ranked candidate");

    // Ranked entries never exceed the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_EMIT)) |-> (rank_reg < limit_reg))
        else $error("rank count beyond limit");

    // A finish clears the live counters and starts the sum walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && cmd_valid && (cmd.op == CMD_FINISH)
        |=> (state_reg == ST_SUM) && (idx_reg == '0) && (live_reg[0] == '0))
        else $error("finish did not start summary walk");

endmodule

`default_nettype wire

// ===== hdl/event_histogram_top_k.sv =====
// Event histogram with top-k ranking. Requests enter through a front stage
// that drops unused actions and out-of-table hits, then wait in a four-entry
// command queue, so s_ready stays high while the queue has room even while a
// result waits on m_ready. The back end executes a hit without waiting and a
// query once its output register is free. A finish snapshots and clears the
// table, sums the snapshot one entry at a time, emits a summary record unless
// the total is zero, then emits limit ranked entries, each after a linear
// scan of the snapshot; limit is the smaller of top_limit and the number of
// nonzero kinds. During that walk hits keep queuing until the queue fills.
// top_limit is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module event_histogram_top_k (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ehtk_pkg::LIM_W-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic [ehtk_pkg::ID_W-1:0]     s_event_id,
    input  wire logic [ehtk_pkg::NAV_W-1:0]    s_nav_id,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_record_kind,
    output logic [ehtk_pkg::NAV_W-1:0]         m_out_nav,
    output logic [ehtk_pkg::DIST_W-1:0]        m_distinct_kinds,
    output logic [ehtk_pkg::TOT_W-1:0]         m_total_hits,
    output logic [ehtk_pkg::ID_W-1:0]          m_kind_out,
    output logic [ehtk_pkg::CNT_W-1:0]         m_kind_count,
    output logic                               m_last
);
    import ehtk_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;
    rec_t rec;

    ehtk_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_event_id (s_event_id),
        .s_nav_id   (s_nav_id),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    ehtk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    ehtk_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (q_valid),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rec       (rec)
    );

    assign m_record_kind    = rec.record_kind;
    assign m_out_nav        = rec.out_nav;
    assign m_distinct_kinds = rec.distinct_kinds;
    assign m_total_hits     = rec.total_hits;
    assign m_kind_out       = rec.kind_out;
    assign m_kind_count     = rec.kind_count;
    assign m_last           = rec.last;

endmodule

`default_nettype wire
